// ===== hdl/ntta_pkg.sv =====
// ntta_pkg: shared types and codes for the node table with ttl aging
// used by the front end, the queue, the table engine and the top level
// no dependencies

package ntta_pkg;

    localparam int MAC_W   = 48;
    localparam int LEVEL_W = 8;
    localparam int TTL_W   = 16;
    localparam int KIND_W  = 3;
    localparam int OP_W    = 2;

    // apb register map: one register, decoded on the top address bit
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam logic [TTL_W-1:0] TTL_RELOAD_RST = 16'd70;
    localparam logic REG_TTL_RELOAD = 1'b0;

    // command queue between front end and engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // classified operations
    localparam logic [OP_W-1:0] OP_REPORT = 2'd0;
    localparam logic [OP_W-1:0] OP_AGE    = 2'd1;
    localparam logic [OP_W-1:0] OP_NOTE   = 2'd2;

    // event kinds
    localparam logic [KIND_W-1:0] EV_JOIN    = 3'd0;
    localparam logic [KIND_W-1:0] EV_CHANGE  = 3'd1;
    localparam logic [KIND_W-1:0] EV_REFRESH = 3'd2;
    localparam logic [KIND_W-1:0] EV_FULL    = 3'd3;
    localparam logic [KIND_W-1:0] EV_LEAVE   = 3'd4;
    localparam logic [KIND_W-1:0] EV_DONE    = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [MAC_W-1:0]   mac;
        logic [LEVEL_W-1:0] level;
    } q_item_t;

    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [LEVEL_W-1:0] level;
        logic [TTL_W-1:0]   ttl;
    } entry_t;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
    } q_stat_t;

endpackage

// ===== hdl/node_table_ttl_aging.sv =====
// node_table_ttl_aging: mesh node table with ttl aging, top level
// depends on ntta_pkg, ntta_front, ntta_fifo and ntta_engine
//
// s_ channel: one transfer per item; s_cmd 0 is a node report (s_mac, s_level),
// s_cmd 1 is an aging tick that ages the table only when s_local_is_root is set.
// m_ channel: a report gives one event (join, level change, refresh or table
// full); a tick gives one leave event per expired slot in slot order, then a
// done event. m_last marks the final event of each item.
// apb port: register 0 at address 0 is ttl_reload (16 bits, reset 70); write
// only while the block is idle.
// path: an input transfer is registered in the front end and queued; the engine
// pops it when idle. A report walk ends early on a hit; a root tick walks every
// slot and each leave waits on the receiver; a tick off root gives only its done event.
// throughput: one item at a time, one slot read per cycle while no event waits on
// the receiver.
// a four-entry command queue takes transfers while the engine walks; it fills
// and s_ready drops if m_ready stays low, the walk holding at the next emit.
// reset: all slots become free, ttl_reload returns to 70, queue and result
// register empty; no clearing pass is needed.

module node_table_ttl_aging #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [ntta_pkg::MAC_W-1:0]      s_mac,
    input  logic [ntta_pkg::LEVEL_W-1:0]    s_level,
    input  logic                            s_local_is_root,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ntta_pkg::KIND_W-1:0]     m_event_kind,
    output logic [ntta_pkg::MAC_W-1:0]      m_event_mac,
    output logic [ntta_pkg::LEVEL_W-1:0]    m_event_level,
    output logic                            m_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ntta_pkg::ADDR_W-1:0]     paddr,
    input  logic [ntta_pkg::DATA_W-1:0]     pwdata,
    output logic [ntta_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import ntta_pkg::*;

    logic [TTL_W-1:0] ttl_reload_reg;
    logic             cfg_wr;
    logic             q_push, q_pop, q_empty;
    q_item_t          push_item, pop_item;
    q_stat_t          q_stat;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_TTL_RELOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reload_reg <= TTL_RELOAD_RST;
        end else if (cfg_wr) begin
            ttl_reload_reg <= pwdata[TTL_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_TTL_RELOAD) ?
                    {{(DATA_W-TTL_W){1'b0}}, ttl_reload_reg} : '0;

    // front end: transfer register and classification
    ntta_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_mac           (s_mac),
        .s_level         (s_level),
        .s_local_is_root (s_local_is_root),
        .q_stat          (q_stat),
        .q_push          (q_push),
        .q_item          (push_item)
    );

    // command queue
    ntta_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .stat      (q_stat),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // table engine
    ntta_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ttl_reload    (ttl_reload_reg),
        .q_item        (pop_item),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_event_mac   (m_event_mac),
        .m_event_level (m_event_level),
        .m_last        (m_last)
    );

endmodule

// ===== hdl/ntta_fifo.sv =====
// ntta_fifo: short command queue between the front end and the table engine
// depends on ntta_pkg for the item type and depth

module ntta_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ntta_pkg::q_item_t push_item,
    output ntta_pkg::q_stat_t stat,
    input  logic             pop,
    output ntta_pkg::q_item_t pop_item,
    output logic             empty
);
    import ntta_pkg::*;

    q_item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign stat.full = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !stat.full;
    assign do_pop    = pop && !empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/ntta_front.sv =====
// ntta_front: input transfer register and command classification
// depends on ntta_pkg; feeds ntta_fifo

module ntta_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [ntta_pkg::MAC_W-1:0]     s_mac,
    input  logic [ntta_pkg::LEVEL_W-1:0]   s_level,
    input  logic                           s_local_is_root,
    input  ntta_pkg::q_stat_t              q_stat,
    output logic                           q_push,
    output ntta_pkg::q_item_t              q_item
);
    import ntta_pkg::*;

    logic    hold_vld_reg, hold_vld_next;
    q_item_t hold_item_reg;
    q_item_t cls_item;
    logic    take;

    assign q_push  = hold_vld_reg && !q_stat.full;
    assign s_ready = !hold_vld_reg || !q_stat.full;
    assign take    = s_valid && s_ready;
    assign q_item  = hold_item_reg;

    // classify: a tick off root only needs its done event
    always_comb begin
        cls_item.mac   = s_mac;
        cls_item.level = s_level;
        if (!s_cmd) begin
            cls_item.op = OP_REPORT;
        end else if (s_local_is_root) begin
            cls_item.op = OP_AGE;
        end else begin
            cls_item.op = OP_NOTE;
        end
    end

    always_comb begin
        hold_vld_next = hold_vld_reg;
        if (take) begin
            hold_vld_next = 1'b1;
        end else if (q_push) begin
            hold_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            hold_item_reg <= cls_item;
        end
    end

endmodule

// ===== hdl/ntta_engine.sv =====
// ntta_engine: walks the node table for reports and aging ticks, one slot a cycle while no
// event waits on m_ready; depends on ntta_pkg; holds the table memory, valid bits and result register

module ntta_engine #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ntta_pkg::TTL_W-1:0]      ttl_reload,
    input  ntta_pkg::q_item_t               q_item,
    input  logic                            q_empty,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ntta_pkg::KIND_W-1:0]     m_event_kind,
    output logic [ntta_pkg::MAC_W-1:0]      m_event_mac,
    output logic [ntta_pkg::LEVEL_W-1:0]    m_event_level,
    output logic                            m_last
);
    import ntta_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // table storage
    entry_t                 mem [TABLE_DEPTH];
    entry_t                 mem_q_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    logic [1:0]       state_reg, state_next;
    q_item_t          cur_reg, cur_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             s1_vld_reg, s1_vld_next;
    logic [IDX_W-1:0] s1_idx_reg, s1_idx_next;
    logic             free_vld_reg, free_vld_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic               out_vld_reg, out_vld_next;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [MAC_W-1:0]   out_mac_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_last_reg;

    logic               emit_ok, emit, emit_last;
    logic [KIND_W-1:0]  emit_kind;
    logic [MAC_W-1:0]   emit_mac;
    logic [LEVEL_W-1:0] emit_level;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             advance;
    logic             s1_valid_bit, s1_hit, s1_last;

    assign emit_ok      = !out_vld_reg || m_ready;
    assign s1_valid_bit = valid_reg[s1_idx_reg];
    assign s1_hit       = s1_valid_bit && (mem_q_reg.mac == cur_reg.mac);
    assign s1_last      = (s1_idx_reg == LAST_IDX);
    assign rd_addr      = rd_cnt_reg[IDX_W-1:0];
    assign rd_en        = advance && (rd_cnt_reg < CNT_W'(TABLE_DEPTH));

    // walk control and per-slot decisions
    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        rd_cnt_next   = rd_cnt_reg;
        s1_vld_next   = s1_vld_reg;
        s1_idx_next   = s1_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        q_pop         = 1'b0;
        advance       = 1'b0;
        emit          = 1'b0;
        emit_kind     = EV_DONE;
        emit_mac      = '0;
        emit_level    = '0;
        emit_last     = 1'b1;
        mem_we        = 1'b0;
        mem_waddr     = s1_idx_reg;
        mem_wdata     = mem_q_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop         = 1'b1;
                    cur_next      = q_item;
                    rd_cnt_next   = '0;
                    s1_vld_next   = 1'b0;
                    free_vld_next = 1'b0;
                    state_next    = (q_item.op == OP_NOTE) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                if (!s1_vld_reg) begin
                    advance = 1'b1;
                end else if (cur_reg.op == OP_REPORT) begin
                    if (s1_hit) begin
                        // known node: reload ttl, maybe take the new level
                        if (emit_ok) begin
                            emit            = 1'b1;
                            emit_kind       = (mem_q_reg.level != cur_reg.level) ?
                                              EV_CHANGE : EV_REFRESH;
                            emit_mac        = cur_reg.mac;
                            emit_level      = cur_reg.level;
                            mem_we          = 1'b1;
                            mem_wdata.level = cur_reg.level;
                            mem_wdata.ttl   = ttl_reload;
                            s1_vld_next     = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end else if (s1_last) begin
                        // end of table: join at the lowest free slot or report full
                        if (emit_ok) begin
                            emit        = 1'b1;
                            emit_mac    = cur_reg.mac;
                            emit_level  = cur_reg.level;
                            s1_vld_next = 1'b0;
                            state_next  = ST_IDLE;
                            if (free_vld_reg || !s1_valid_bit) begin
                                emit_kind       = EV_JOIN;
                                mem_we          = 1'b1;
                                mem_waddr       = free_vld_reg ? free_idx_reg : s1_idx_reg;
                                mem_wdata.mac   = cur_reg.mac;
                                mem_wdata.level = cur_reg.level;
                                mem_wdata.ttl   = ttl_reload;
                                valid_next[mem_waddr] = 1'b1;
                            end else begin
                                emit_kind = EV_FULL;
                            end
                        end
                    end else begin
                        advance = 1'b1;
                        if (!s1_valid_bit && !free_vld_reg) begin
                            free_vld_next = 1'b1;
                            free_idx_next = s1_idx_reg;
                        end
                    end
                end else begin
                    // aging: expired slots leave, the rest count down
                    if (s1_valid_bit && (mem_q_reg.ttl == '0)) begin
                        if (emit_ok) begin
                            emit                   = 1'b1;
                            emit_kind              = EV_LEAVE;
                            emit_mac               = mem_q_reg.mac;
                            emit_level             = mem_q_reg.level;
                            emit_last              = 1'b0;
                            valid_next[s1_idx_reg] = 1'b0;
                            advance                = 1'b1;
                        end
                    end else begin
                        advance = 1'b1;
                        if (s1_valid_bit) begin
                            mem_we        = 1'b1;
                            mem_wdata.ttl = mem_q_reg.ttl - TTL_W'(1);
                        end
                    end
                    if (advance && s1_last) begin
                        state_next = ST_DONE;
                    end
                end

                // issue the next slot read
                if (advance) begin
                    s1_vld_next = (rd_cnt_reg < CNT_W'(TABLE_DEPTH));
                    s1_idx_next = rd_addr;
                    rd_cnt_next = rd_en ? rd_cnt_reg + CNT_W'(1) : rd_cnt_reg;
                end
            end
            ST_DONE: begin
                if (emit_ok) begin
                    emit       = 1'b1;
                    emit_kind  = EV_DONE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        out_vld_next = out_vld_reg;
        if (emit) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            s1_vld_reg   <= 1'b0;
            free_vld_reg <= 1'b0;
            valid_reg    <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            s1_vld_reg   <= s1_vld_next;
            free_vld_reg <= free_vld_next;
            valid_reg    <= valid_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        s1_idx_reg   <= s1_idx_next;
        free_idx_reg <= free_idx_next;
        if (emit) begin
            out_kind_reg  <= emit_kind;
            out_mac_reg   <= emit_mac;
            out_level_reg <= emit_level;
            out_last_reg  <= emit_last;
        end
    end

    // table memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_event_kind  = out_kind_reg;
    assign m_event_mac   = out_mac_reg;
    assign m_event_level = out_level_reg;
    assign m_last        = out_last_reg;

endmodule

// ===== dv/node_table_ttl_aging_tb.sv =====
// node_table_ttl_aging_tb: self-checking bench for the mesh node table with ttl aging
// drives node reports and aging ticks, predicts join, change, refresh, full, leave and done
// events from its own copy of the table; depends on ntta_pkg and node_table_ttl_aging

module node_table_ttl_aging_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ntta_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_PRINTS   = 50;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [ADDR_W-1:0] TTL_RELOAD_ADDR = ADDR_W'(4 * REG_TTL_RELOAD);

    typedef struct packed {
        logic               cmd;
        logic [MAC_W-1:0]   mac;
        logic [LEVEL_W-1:0] level;
        logic               root;
    } node_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [MAC_W-1:0]   mac;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } node_event_t;

    // dut ports
    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_cmd = 1'b0;
    logic [MAC_W-1:0]    s_mac = '0;
    logic [LEVEL_W-1:0]  s_level = '0;
    logic                s_local_is_root = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [KIND_W-1:0]   m_event_kind;
    logic [MAC_W-1:0]    m_event_mac;
    logic [LEVEL_W-1:0]  m_event_level;
    logic                m_last;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // shadow table and register
    logic                slot_used  [TABLE_DEPTH];
    logic [MAC_W-1:0]    slot_mac   [TABLE_DEPTH];
    logic [LEVEL_W-1:0]  slot_level [TABLE_DEPTH];
    logic [TTL_W-1:0]    slot_ttl   [TABLE_DEPTH];
    logic [TTL_W-1:0]    cur_reload = TTL_RELOAD_RST;

    node_item_t          pending_items [$];
    node_event_t         exp_events [$];
    logic [MAC_W-1:0]    known_macs [$];
    logic [LEVEL_W-1:0]  known_level [bit [MAC_W-1:0]];

    // handshake history and pacing
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    bit   quiet = 1'b0;
    int   hold_asks = 0;
    int   hold_taken = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   stall_left = 0;

    // run statistics
    int mismatch_count = 0;
    int items_taken = 0;
    int results_seen = 0;
    int leaves_seen = 0;
    int full_seen = 0;
    int cycle_count = 0;
    int last_reload = 0;

    node_table_ttl_aging #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_mac(s_mac),
        .s_level(s_level),
        .s_local_is_root(s_local_is_root),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_event_kind(m_event_kind),
        .m_event_mac(m_event_mac),
        .m_event_level(m_event_level),
        .m_last(m_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // failure log: one line per failure, printing capped
    task automatic log_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic queue_event(logic [KIND_W-1:0] kind, logic [MAC_W-1:0] mac,
                               logic [LEVEL_W-1:0] lvl, logic last);
        node_event_t ev;
        ev.kind  = kind;
        ev.mac   = mac;
        ev.level = lvl;
        ev.last  = last;
        exp_events.push_back(ev);
    endtask

    // table behavior for one accepted item
    task automatic predict_events(logic cmd, logic [MAC_W-1:0] mac,
                                  logic [LEVEL_W-1:0] lvl, logic root);
        int  free_slot;
        int  i;
        bit  hit;
        free_slot = -1;
        hit = 1'b0;
        if (cmd == CMD_REPORT) begin
            for (i = 0; i < TABLE_DEPTH && !hit; i++) begin
                if (slot_used[i] && slot_mac[i] == mac) begin
                    hit = 1'b1;
                    slot_ttl[i] = cur_reload;
                    if (slot_level[i] != lvl) begin
                        slot_level[i] = lvl;
                        queue_event(EV_CHANGE, mac, lvl, 1'b1);
                    end else begin
                        queue_event(EV_REFRESH, mac, lvl, 1'b1);
                    end
                end else if (!slot_used[i] && free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (!hit) begin
                if (free_slot < 0) begin
                    queue_event(EV_FULL, mac, lvl, 1'b1);
                end else begin
                    slot_used[free_slot]  = 1'b1;
                    slot_mac[free_slot]   = mac;
                    slot_level[free_slot] = lvl;
                    slot_ttl[free_slot]   = cur_reload;
                    queue_event(EV_JOIN, mac, lvl, 1'b1);
                end
            end
        end else begin
            if (root) begin
                for (i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_used[i]) begin
                        if (slot_ttl[i] == '0) begin
                            slot_used[i] = 1'b0;
                            queue_event(EV_LEAVE, slot_mac[i], slot_level[i], 1'b0);
                        end else begin
                            slot_ttl[i] = slot_ttl[i] - 1'b1;
                        end
                    end
                end
            end
            queue_event(EV_DONE, '0, '0, 1'b1);
        end
    endtask

    // input transfers feed the predictor, result transfers are checked
    always @(posedge aclk) begin : scoreboard
        node_event_t want;
        in_fire  <= aresetn && s_valid && s_ready;
        out_fire <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            items_taken++;
            predict_events(s_cmd, s_mac, s_level, s_local_is_root);
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_event_kind == EV_LEAVE) leaves_seen++;
            if (m_event_kind == EV_FULL) full_seen++;
            if (exp_events.size() == 0) begin
                log_failure($sformatf("result kind %0d with nothing expected", m_event_kind));
            end else begin
                want = exp_events.pop_front();
                if (m_event_kind !== want.kind)
                    log_failure($sformatf("event_kind got %0d want %0d",
                                          m_event_kind, want.kind));
                if (m_event_mac !== want.mac)
                    log_failure($sformatf("event_mac got %h want %h", m_event_mac, want.mac));
                if (m_event_level !== want.level)
                    log_failure($sformatf("event_level got %h want %h",
                                          m_event_level, want.level));
                if (m_last !== want.last)
                    log_failure($sformatf("last got %b want %b", m_last, want.last));
            end
        end
    end

    // sender: one item per transfer, random gap after each
    always @(negedge aclk) begin : sender
        node_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || in_fire) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (pending_items.size() != 0) begin
                it = pending_items.pop_front();
                s_valid         <= 1'b1;
                s_cmd           <= it.cmd;
                s_mac           <= it.mac;
                s_level         <= it.level;
                s_local_is_root <= it.root;
                send_gap = quiet ? 0 : $urandom_range(0, 11);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random wait after each result, plus an occasional long hold
    always @(negedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (hold_asks != hold_taken) begin
                hold_taken = hold_asks;
                stall_left = LONG_HOLD;
            end
            if (out_fire) recv_gap = quiet ? 0 : $urandom_range(0, 11);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, exp_events.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic check_ttl_reload(logic [TTL_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TTL_RELOAD_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[TTL_W-1:0] !== value)
            log_failure($sformatf("ttl_reload read %0d want %0d", prdata[TTL_W-1:0], value));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_ttl_reload(logic [TTL_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TTL_RELOAD_ADDR;
        pwdata  <= DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cur_reload = value;
        last_reload = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_ttl_reload(value);
    endtask

    // block idle: all items taken, all results in, then the walk latency
    task automatic wait_drained();
        int k;
        while (pending_items.size() != 0 || s_valid || exp_events.size() != 0)
            @(posedge aclk);
        for (k = 0; k < DRAIN_CYCLES; k++) @(posedge aclk);
    endtask

    task automatic add_item(logic cmd, logic [MAC_W-1:0] mac, logic [LEVEL_W-1:0] lvl,
                            logic root);
        node_item_t it;
        it.cmd   = cmd;
        it.mac   = mac;
        it.level = lvl;
        it.root  = root;
        pending_items.push_back(it);
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [MAC_W-1:0] m;
        m[47:32] = 16'($urandom_range(0, 65535));
        m[31:0]  = $urandom();
        return m;
    endfunction

    // report from a fresh mac or a known one, often with its last level
    task automatic add_report(int new_pct);
        logic [MAC_W-1:0]   m;
        logic [LEVEL_W-1:0] l;
        if (known_macs.size() == 0 || $urandom_range(0, 99) < new_pct) begin
            m = rand_mac();
            known_macs.push_back(m);
            l = $urandom_range(0, 255);
        end else begin
            m = known_macs[$urandom_range(0, known_macs.size() - 1)];
            l = ($urandom_range(0, 99) < 60) ? known_level[m] : 8'($urandom_range(0, 255));
        end
        known_level[m] = l;
        add_item(CMD_REPORT, m, l, 1'($urandom_range(0, 1)));
    endtask

    task automatic add_random_items(int count, int report_pct, int new_pct, int root_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < report_pct) begin
                add_report(new_pct);
            end else begin
                add_item(CMD_TICK, rand_mac(), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 99) < root_pct);
            end
        end
    endtask

    // stimulus phases
    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_used[i]  = 1'b0;
            slot_mac[i]   = '0;
            slot_level[i] = '0;
            slot_ttl[i]   = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_ttl_reload(TTL_RELOAD_RST);

        // directed: ticks on empty table, joins at the mac extremes, refresh, change
        add_item(CMD_TICK, '1, '1, 1'b0);
        add_item(CMD_TICK, '0, '0, 1'b1);
        add_item(CMD_REPORT, '0, '0, 1'b0);
        add_item(CMD_REPORT, '1, 8'hff, 1'b1);
        add_item(CMD_REPORT, '1, 8'hff, 1'b0);
        add_item(CMD_REPORT, '1, 8'h00, 1'b0);
        add_item(CMD_REPORT, '0, '0, 1'b1);
        add_item(CMD_TICK, '0, '0, 1'b1);
        wait_drained();

        // directed: zero reload, off-root tick leaves the table alone, leaves in slot order
        set_ttl_reload('0);
        add_item(CMD_REPORT, '0, 8'h80, 1'b0);
        add_item(CMD_REPORT, 48'h5555_5555_5555, 8'haa, 1'b0);
        add_item(CMD_TICK, '0, '0, 1'b0);
        add_item(CMD_TICK, '0, '0, 1'b1);
        add_item(CMD_REPORT, 48'haaaa_aaaa_aaaa, 8'h55, 1'b1);
        add_item(CMD_TICK, 48'h5555_5555_5555, 8'h55, 1'b1);
        wait_drained();

        // fill past capacity with zero reload and no aging, then age it all away at once
        add_random_items(70, 88, 60, 0);
        add_item(CMD_TICK, rand_mac(), 8'($urandom_range(0, 255)), 1'b1);
        wait_drained();

        // maximum reload, back to back traffic against one long receiver hold
        set_ttl_reload('1);
        quiet = 1'b1;
        hold_asks++;
        add_random_items(45, 60, 30, 80);
        wait_drained();
        quiet = 1'b0;

        // short reload with frequent root ticks so entries come and go
        set_ttl_reload(TTL_W'($urandom_range(1, 6)));
        add_random_items(40, 55, 25, 85);
        wait_drained();

        if (exp_events.size() != 0)
            log_failure($sformatf("%0d results never arrived", exp_events.size()));
        $display("%0d items transferred, %0d results checked (%0d leave, %0d table full)",
                 items_taken, results_seen, leaves_seen, full_seen);
        $display("ttl reload run at 70, 0, 65535 and %0d, with a %0d cycle receiver hold",
                 last_reload, LONG_HOLD);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ntta_pkg.sv
hdl/ntta_fifo.sv
hdl/ntta_front.sv
hdl/ntta_engine.sv
hdl/node_table_ttl_aging.sv
dv/node_table_ttl_aging_tb.sv
